FILE: hdl/octal_escape_line_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the octal escape line encoder
// Shared forms of clocked implication checks with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef OCTAL_ESCAPE_LINE_ENCODER_UNIT_MACROS_SVH
`define OCTAL_ESCAPE_LINE_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OELE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oele same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define OELE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oele next-cycle check failed");

`endif

FILE: hdl/oele_pkg.sv
// ----------------------------------------------------------------------------
// oele_pkg
// Shared constants, command type and classification helper.
// ----------------------------------------------------------------------------
`default_nettype none

package oele_pkg;

    localparam int DATA_W      = 8;
    localparam int COL_W       = 9;
    localparam int LIMIT_W     = 8;
    localparam int STEP_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd70;

    localparam logic [DATA_W-1:0] ESC_CHAR   = 8'h3D;
    localparam logic [DATA_W-1:0] NL_CHAR    = 8'h0A;
    localparam logic [DATA_W-1:0] DIGIT_BASE = 8'h30;
    localparam logic [DATA_W-1:0] BACKSLASH  = 8'h5C;
    localparam logic [DATA_W-1:0] PRINT_LO   = 8'h21;
    localparam logic [DATA_W-1:0] PRINT_HI   = 8'h7E;

    // Register index (byte address divided by four)
    localparam logic [0:0] REG_LINE_LIMIT = 1'b0;

    // Character positions within one request's output run
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DIG_HI = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DIG_MID = 3'd2;
    localparam logic [STEP_W-1:0] STEP_DIG_LO = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ESC_NL = 3'd4;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              escape;
        logic              wrap;
        logic              nul;
    } oele_cmd_t;

    function automatic logic needs_escape(input logic [DATA_W-1:0] b);
        logic res;
        res = (b == BACKSLASH) || (b == ESC_CHAR) || (b < PRINT_LO) || (b > PRINT_HI);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/oele_in_if.sv
// ----------------------------------------------------------------------------
// oele_in_if
// Input channel: one text byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface oele_in_if;
    logic                         valid;
    logic                         ready;
    logic [oele_pkg::DATA_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/oele_out_if.sv
// ----------------------------------------------------------------------------
// oele_out_if
// Output channel: one encoded character per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface oele_out_if;
    logic                         valid;
    logic                         ready;
    logic [oele_pkg::DATA_W-1:0]  out_char;
    logic                         last_of_run;
    logic                         record_end;

    modport source (output valid, output out_char, output last_of_run,
                    output record_end, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input record_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/oele_front.sv
// ----------------------------------------------------------------------------
// oele_front
// Accept bytes, classify them and track the line column.
// ----------------------------------------------------------------------------
`default_nettype none

`include "octal_escape_line_encoder_unit_macros.svh"

module oele_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    oele_in_if.sink                            in_ch,
    input  wire logic [oele_pkg::LIMIT_W-1:0]  line_limit,
    output      logic                          push_valid,
    input  wire logic                          push_ready,
    output      oele_pkg::oele_cmd_t           push_cmd
);

    logic [oele_pkg::COL_W-1:0] col_reg;
    logic [oele_pkg::COL_W-1:0] col_next;
    logic [oele_pkg::COL_W-1:0] col_sum;
    logic                       esc;
    logic                       nul;
    logic                       wrap;
    logic                       accept;

    assign esc    = oele_pkg::needs_escape(in_ch.data_byte);
    assign nul    = (in_ch.data_byte == '0);
    assign col_sum = col_reg + (esc ? oele_pkg::COL_W'(4) : oele_pkg::COL_W'(1));
    assign wrap   = (col_sum >= {1'b0, line_limit}) || nul;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign accept      = in_ch.valid && push_ready;

    always_comb
    begin
        push_cmd.data_byte = in_ch.data_byte;
        push_cmd.escape    = esc;
        push_cmd.wrap      = wrap;
        push_cmd.nul       = nul;
    end

    always_comb
    begin
        col_next = col_reg;
        if (accept)
        begin
            col_next = wrap ? '0 : col_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    // Without a wrap the column stays below a limit of at most 255
    `OELE_ASSERT_SAME(a_col_bound, clk, rst_n, 1'b1, col_reg <= oele_pkg::COL_W'(254))

endmodule

`default_nettype wire

FILE: hdl/oele_queue.sv
// ----------------------------------------------------------------------------
// oele_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "octal_escape_line_encoder_unit_macros.svh"

module oele_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output      logic                 push_ready,
    input  wire oele_pkg::oele_cmd_t  push_cmd,
    input  wire logic                 pop,
    output      logic                 head_valid,
    output      oele_pkg::oele_cmd_t  head_cmd
);

    oele_pkg::oele_cmd_t               slot_reg [oele_pkg::QUEUE_DEPTH];
    logic [oele_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [oele_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [oele_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [oele_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [oele_pkg::QCNT_W-1:0]       count_reg;
    logic [oele_pkg::QCNT_W-1:0]       count_next;
    logic                              push;
    logic                              do_pop;

    localparam logic [oele_pkg::QPTR_W-1:0] PTR_LAST = oele_pkg::QPTR_W'(oele_pkg::QUEUE_DEPTH - 1);
    localparam logic [oele_pkg::QCNT_W-1:0] CNT_FULL = oele_pkg::QCNT_W'(oele_pkg::QUEUE_DEPTH);

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `OELE_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)

endmodule

`default_nettype wire

FILE: hdl/oele_back.sv
// ----------------------------------------------------------------------------
// oele_back
// Expand each queued command into characters, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "octal_escape_line_encoder_unit_macros.svh"

module oele_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire oele_pkg::oele_cmd_t  head_cmd,
    output      logic                 pop,
    oele_out_if.source                out_ch
);

    logic [oele_pkg::STEP_W-1:0] step_reg;
    logic [oele_pkg::STEP_W-1:0] step_next;
    logic [oele_pkg::STEP_W-1:0] last_step;
    logic                        is_last;
    logic                        load;
    logic [oele_pkg::DATA_W-1:0] char_sel;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [oele_pkg::DATA_W-1:0] out_char_reg;
    logic                        last_of_run_reg;
    logic                        record_end_reg;

    assign load = head_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        if (head_cmd.escape)
        begin
            last_step = head_cmd.wrap ? oele_pkg::STEP_ESC_NL : oele_pkg::STEP_DIG_LO;
        end
        else
        begin
            last_step = head_cmd.wrap ? oele_pkg::STEP_DIG_HI : oele_pkg::STEP_FIRST;
        end
    end

    assign is_last = (step_reg == last_step);
    assign pop     = load && is_last;

    always_comb
    begin
        char_sel = oele_pkg::NL_CHAR;
        unique case (step_reg)
            oele_pkg::STEP_FIRST:
            begin
                char_sel = head_cmd.escape ? oele_pkg::ESC_CHAR : head_cmd.data_byte;
            end
            oele_pkg::STEP_DIG_HI:
            begin
                if (head_cmd.escape)
                begin
                    char_sel = oele_pkg::DIGIT_BASE | {6'd0, head_cmd.data_byte[7:6]};
                end
            end
            oele_pkg::STEP_DIG_MID:
            begin
                char_sel = oele_pkg::DIGIT_BASE | {5'd0, head_cmd.data_byte[5:3]};
            end
            oele_pkg::STEP_DIG_LO:
            begin
                char_sel = oele_pkg::DIGIT_BASE | {5'd0, head_cmd.data_byte[2:0]};
            end
            default:
            begin
                char_sel = oele_pkg::NL_CHAR;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = is_last ? oele_pkg::STEP_FIRST : step_reg + 1'b1;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= oele_pkg::STEP_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg    <= char_sel;
            last_of_run_reg <= is_last;
            record_end_reg  <= is_last && head_cmd.nul;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_char    = out_char_reg;
    assign out_ch.last_of_run = last_of_run_reg;
    assign out_ch.record_end  = record_end_reg;

    // Mid-run the command stays at the queue head and the step stays in range
    `OELE_ASSERT_SAME(a_head_held, clk, rst_n, step_reg != oele_pkg::STEP_FIRST,
                      head_valid && (step_reg <= last_step))
    // A record end is always the closing newline of its run
    `OELE_ASSERT_SAME(a_rec_end_nl, clk, rst_n, out_valid_reg && record_end_reg,
                      last_of_run_reg && (out_char_reg == oele_pkg::NL_CHAR))
    // Releasing a command restarts the character sequence
    `OELE_ASSERT_NEXT(a_pop_restart, clk, rst_n, pop, step_reg == oele_pkg::STEP_FIRST)

endmodule

`default_nettype wire

FILE: hdl/octal_escape_line_encoder_unit.sv
// ----------------------------------------------------------------------------
// octal_escape_line_encoder_unit
// Octal escape encoder with line wrap: text bytes in, encoded characters out.
// ----------------------------------------------------------------------------
//
//   Channel   Kind        Carries
//   -------   ---------   ------------------------------------------------
//   in_ch     valid/ready data_byte, one text byte per request
//   out_ch    valid/ready out_char, last_of_run, record_end per request
//   APB       write/read  line_limit at byte address 0
//
// A byte yields 1 (plain byte), 2 (plain byte and newline), 4 (escape)
// or 5 (escape and newline) characters; the single output register of
// the back part emits one character per cycle unless out_ch stalls.
// The front part takes a new byte every cycle while the two-entry command
// queue has room, so bytes are accepted while earlier ones are still emitted.
// Reset (rst_n, asynchronous, active low) clears the column count, the queue,
// the output stage and restores line_limit to 70; no clearing pass is needed.
// An output stall fills the queue and then holds in_ch.ready low.
//
`default_nettype none

module octal_escape_line_encoder_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    oele_in_if.sink                               in_ch,
    oele_out_if.source                            out_ch,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [oele_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [oele_pkg::APB_DATA_W-1:0]  pwdata,
    output      logic [oele_pkg::APB_DATA_W-1:0]  prdata,
    output      logic                             pready
);

    logic [oele_pkg::LIMIT_W-1:0] line_limit_reg;
    logic [oele_pkg::LIMIT_W-1:0] line_limit_next;
    logic                         cfg_write;
    logic                         push_valid;
    logic                         push_ready;
    oele_pkg::oele_cmd_t          push_cmd;
    logic                         pop;
    logic                         head_valid;
    oele_pkg::oele_cmd_t          head_cmd;

    // Configuration: zero-wait APB, register index taken from the word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        line_limit_next = line_limit_reg;
        // drop writes to addresses beyond the register list
        if (cfg_write && (paddr[2] == oele_pkg::REG_LINE_LIMIT))
        begin
            line_limit_next = pwdata[oele_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= oele_pkg::LIMIT_RESET;
        end
        else
        begin
            line_limit_reg <= line_limit_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == oele_pkg::REG_LINE_LIMIT)
        begin
            prdata = {{(oele_pkg::APB_DATA_W - oele_pkg::LIMIT_W){1'b0}}, line_limit_reg};
        end
    end

    // Front: classify each byte, advance the column and decide the wrap
    oele_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .line_limit (line_limit_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Queue: hold classified commands so front and back stall independently
    oele_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: expand the head command into characters through the output register
    oele_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

FILE: dv/octal_escape_line_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// octal_escape_line_encoder_unit_tb
// Self-checking bench for the octal escape line encoder. It drives text bytes
// on in_ch and programs line_limit over APB. An internal encoder model keeps
// its own column count and limit, and a monitor compares every character on
// out_ch with the oldest predicted one. Directed bytes cover the escape
// classes and the limit corner cases. Random records then run under several
// idle and stall patterns, including a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module octal_escape_line_encoder_unit_tb;

    // Register map: line_limit is the only register; the next word is unused
    localparam int REG_STRIDE = 4;
    localparam logic [oele_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = {oele_pkg::REG_LINE_LIMIT, 2'b00};
    localparam logic [oele_pkg::APB_ADDR_W-1:0] SPARE_ADDR =
        oele_pkg::APB_ADDR_W'(LIMIT_ADDR + REG_STRIDE);

    localparam logic [oele_pkg::DATA_W-1:0] NUL_BYTE = 8'h00;

    // One predicted output character
    typedef struct packed {
        logic [oele_pkg::DATA_W-1:0] glyph;
        logic                        last_of_run;
        logic                        record_end;
    } enc_char_t;

    logic clk;
    logic rst_n;

    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [oele_pkg::APB_ADDR_W-1:0] paddr;
    logic [oele_pkg::APB_DATA_W-1:0] pwdata;
    logic [oele_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    oele_in_if  in_ch ();
    oele_out_if out_ch ();

    octal_escape_line_encoder_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Encoder model state: a copy of the limit register and the column count
    logic [oele_pkg::LIMIT_W-1:0] limit_shadow;
    logic [oele_pkg::COL_W-1:0]   col_count;

    // Characters predicted but not yet seen on out_ch, oldest first
    enc_char_t expected_chars[$];

    int fail_count    = 0;
    int bytes_sent    = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_off_left = 0;

    // ------------------------------------------------------------------------
    // Clock, 12 units per period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Encoder model: push the characters one accepted byte will produce.
    // Escapes are '=' plus three octal digits, high digit first; the column
    // count advances by the run length and a newline follows when the count
    // reaches the limit or the byte is NUL.
    // ------------------------------------------------------------------------
    function automatic void encode_byte(input logic [oele_pkg::DATA_W-1:0] b);
        logic [oele_pkg::DATA_W-1:0] glyph [4];
        logic                        escaped;
        logic                        wrap;
        int                          n;
        int                          k;
        escaped = (b == oele_pkg::BACKSLASH) || (b == oele_pkg::ESC_CHAR) ||
                  (b < oele_pkg::PRINT_LO) || (b > oele_pkg::PRINT_HI);
        if (escaped)
        begin
            glyph[0] = oele_pkg::ESC_CHAR;
            glyph[1] = oele_pkg::DIGIT_BASE + {6'd0, b[7:6]};
            glyph[2] = oele_pkg::DIGIT_BASE + {5'd0, b[5:3]};
            glyph[3] = oele_pkg::DIGIT_BASE + {5'd0, b[2:0]};
            n = 4;
        end
        else
        begin
            glyph[0] = b;
            n = 1;
        end
        col_count = col_count + oele_pkg::COL_W'(n);
        // "At or above": a limit lowered below the count ends the line at once
        wrap = (col_count >= {1'b0, limit_shadow}) || (b == NUL_BYTE);
        for (k = 0; k < n; k++)
            expected_chars.push_back('{glyph[k], !wrap && (k == n - 1), 1'b0});
        if (wrap)
        begin
            expected_chars.push_back('{oele_pkg::NL_CHAR, 1'b1, b == NUL_BYTE});
            col_count = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output monitor: compare each accepted character with the oldest
    // prediction, field by field; carry on after a mismatch.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected character %h, nothing predicted",
                         $time, out_ch.out_char);
                fail_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_ch.out_char !== want.glyph)
                begin
                    $display("%0t: out_char expected %h got %h",
                             $time, want.glyph, out_ch.out_char);
                    fail_count++;
                end
                if (out_ch.last_of_run !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last_of_run, out_ch.last_of_run);
                    fail_count++;
                end
                if (out_ch.record_end !== want.record_end)
                begin
                    $display("%0t: record_end expected %b got %b",
                             $time, want.record_end, out_ch.record_end);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: a hold-off counts down in cycles and keeps ready low for
    // its whole length; otherwise stall at the current rate.
    // ------------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Shared helpers; each is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one byte, idling first at the current rate; predict on acceptance
    task automatic send_byte(input logic [oele_pkg::DATA_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        encode_byte(b);
        bytes_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // Hold until every predicted character has come out
    task automatic wait_all_delivered();
        while (expected_chars.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Setup cycle then access cycle; the register takes the data at the
    // access edge, so update the model copy alongside
    task automatic apb_write(input logic [oele_pkg::APB_ADDR_W-1:0] addr,
                             input logic [oele_pkg::APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == LIMIT_ADDR)
            limit_shadow = data[oele_pkg::LIMIT_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_limit_readback();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = LIMIT_ADDR;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[oele_pkg::LIMIT_W-1:0] !== limit_shadow)
        begin
            $display("%0t: line_limit readback expected %h got %h",
                     $time, limit_shadow, prdata[oele_pkg::LIMIT_W-1:0]);
            fail_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Drain, then program a new limit and confirm it reads back
    task automatic set_line_limit(input logic [oele_pkg::LIMIT_W-1:0] limit);
        wait_all_delivered();
        apb_write(LIMIT_ADDR,
                  {{(oele_pkg::APB_DATA_W - oele_pkg::LIMIT_W){1'b0}}, limit});
        check_limit_readback();
    endtask

    // Any non-NUL byte, weighted towards the escape boundaries; one pick in
    // ten is a fully random byte, which lets the odd stray NUL through
    function automatic logic [oele_pkg::DATA_W-1:0] pick_byte();
        case ($urandom_range(9))
            0, 1, 2, 3:
                return oele_pkg::DATA_W'($urandom_range(oele_pkg::PRINT_LO,
                                                        oele_pkg::PRINT_HI));
            4:
                return $urandom_range(1) ? oele_pkg::BACKSLASH : oele_pkg::ESC_CHAR;
            5, 6:
                return oele_pkg::DATA_W'($urandom_range(1, oele_pkg::PRINT_LO - 1));
            7, 8:
                return oele_pkg::DATA_W'($urandom_range(oele_pkg::PRINT_HI + 1, 255));
            default:
                return oele_pkg::DATA_W'($urandom_range(255));
        endcase
    endfunction

    // A record of random text, nearly always closed by NUL
    task automatic send_record(input int max_len);
        repeat ($urandom_range(max_len))
            send_byte(pick_byte());
        if ($urandom_range(99) < 90)
            send_byte(NUL_BYTE);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Limit must come out of reset at 70
    task automatic test_reset_value();
        check_limit_readback();
    endtask

    // Plain extremes, the bytes just outside them, the two escaped printables,
    // high-bit bytes and NUL closing the record
    task automatic test_escape_classes();
        logic [oele_pkg::DATA_W-1:0] probe [13];
        int                          i;
        probe = '{8'h21, 8'h7E, 8'h20, 8'h7F, oele_pkg::BACKSLASH, oele_pkg::ESC_CHAR,
                  8'hFF, 8'h80, 8'h01, 8'h41, 8'hAA, 8'h55, NUL_BYTE};
        for (i = 0; i < 13; i++)
            send_byte(probe[i]);
    endtask

    // Limit of one and limit of zero: every byte ends its line
    task automatic test_limit_extremes();
        set_line_limit(8'd1);
        send_byte(8'h41);
        send_byte(8'hFF);
        set_line_limit(8'd0);
        send_byte(8'h42);
        send_byte(oele_pkg::NL_CHAR);
        set_line_limit(8'd255);
    endtask

    // Build up nine columns, drop the limit below that, and the next byte
    // must wrap; a write to the unused word must leave the limit alone
    task automatic test_limit_lowered();
        send_byte(8'h7F);
        send_byte(8'h61);
        send_byte(8'h09);
        set_line_limit(8'd5);
        send_byte(8'h62);
        wait_all_delivered();
        apb_write(SPARE_ADDR, 32'h0000_00C7);
        check_limit_readback();
    endtask

    // Long output hold-off while bytes keep coming: the queue fills and
    // in_ch.ready must drop until the hold-off runs out
    task automatic test_output_backpressure();
        set_line_limit(8'd20);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_off_left = 200;
        repeat (24)
            send_byte(pick_byte());
        wait_all_delivered();
    endtask

    // Random records under one limit and one idle pattern; now and then
    // pause the input until everything predicted has come out
    task automatic test_random_traffic(input logic [oele_pkg::LIMIT_W-1:0] limit,
                                       input int src_pct, input int snk_pct,
                                       input int n_bytes, input int max_len);
        int start;
        set_line_limit(limit);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        start         = bytes_sent;
        while (bytes_sent - start < n_bytes)
        begin
            send_record(max_len);
            if ($urandom_range(9) == 0)
                wait_all_delivered();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        limit_shadow    = oele_pkg::LIMIT_RESET;
        col_count       = '0;
        repeat (7)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_value();
        test_escape_classes();
        test_limit_extremes();
        test_limit_lowered();
        test_output_backpressure();

        // Long records with a top limit so the count gets near 255
        test_random_traffic(8'd255, 0, 0, 80, 120);
        test_random_traffic(oele_pkg::LIMIT_W'($urandom_range(1, 255)), 67, 0, 80, 30);
        test_random_traffic(oele_pkg::LIMIT_W'($urandom_range(1, 12)), 0, 67, 80, 20);
        test_random_traffic(oele_pkg::LIMIT_RESET, 33, 33, 80, 40);

        // Let any stray character surface before the verdict
        wait_all_delivered();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
